@@ sv/sra_pkg.sv @@
// Shared constants and types for the sparse row accumulator store
`timescale 1ns / 1ps
package sra_pkg;
    localparam int ROWS_DEF         = 256;
    localparam int ROW_CAPACITY_DEF = 64;
    localparam int COLUMN_BITS_DEF  = 16;
    localparam int ROW_BITS         = 9;
    localparam int COL_PORT_BITS    = 16;
    localparam int VALUE_BITS       = 48;
    localparam int AMOUNT_BITS      = 32;
    localparam int CFG_DATA_BITS    = 16;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic REQ_INCREMENT = 1'b0;
    localparam logic REQ_READ      = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;
endpackage

@@ sv/sra_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sv/sparse_row_accumulator_store.sv @@
// Top level: sparse row store with sorted cell lists and two value planes
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------
//  request   | i_req_type i_plane i_row_index i_column_index  | start & !busy
//            | i_amount                                       |
//  result    | o_value o_hit o_status                         | o_done, one cycle
//  config    | i_cfg_we i_cfg_index i_cfg_data                | i_cfg_we
//
// One item at a time. An out-of-range item gives its result the cycle after accept
// and busy stays low. Others hold busy through the fill read (S_FILL, S_FWAIT), the
// search probes (S_PROBE, S_CMP; up to log2 of row capacity plus one), the cell read,
// a read and a write per shifted cell on insert and the write back; the result shows
// in the first cycle with busy low. Synchronous active-low reset clears control state
// and row fill counts through a valid bit per row. No output stall.
`timescale 1ns / 1ps
module sparse_row_accumulator_store #(
    parameter int ROWS         = sra_pkg::ROWS_DEF,
    parameter int ROW_CAPACITY = sra_pkg::ROW_CAPACITY_DEF,
    parameter int COLUMN_BITS  = sra_pkg::COLUMN_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic                               i_plane,
    input  logic [sra_pkg::ROW_BITS-1:0]       i_row_index,
    input  logic [sra_pkg::COL_PORT_BITS-1:0]  i_column_index,
    input  logic [sra_pkg::AMOUNT_BITS-1:0]    i_amount,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [sra_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                               o_done,
    output logic [sra_pkg::VALUE_BITS-1:0]     o_value,
    output logic                               o_hit,
    output logic [1:0]                         o_status
);
    localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SB    = $clog2(ROW_CAPACITY);
    localparam int FB    = $clog2(ROW_CAPACITY + 1);
    localparam int DEPTH = ROWS * ROW_CAPACITY;
    localparam int AB    = $clog2(DEPTH);
    localparam int VB    = sra_pkg::VALUE_BITS;
    localparam int CELLB = COLUMN_BITS + 2 * VB;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FILL  = 8'b00000010,
        S_FWAIT = 8'b00000100,
        S_PROBE = 8'b00001000,
        S_CMP   = 8'b00010000,
        S_CELL  = 8'b00100000,
        S_SHIFT = 8'b01000000,
        S_WRITE = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [sra_pkg::ROW_BITS-1:0]      r_row_count;
    logic [sra_pkg::COL_PORT_BITS-1:0] r_column_count;
    logic [ROWS-1:0]                   r_fill_valid;
    logic                              r_req, r_plane;
    logic [RB-1:0]                     r_row;
    logic [COLUMN_BITS-1:0]            r_col;
    logic [sra_pkg::AMOUNT_BITS-1:0]   r_amount;
    logic [FB-1:0]                     r_fill, r_lo, r_hi, r_k;
    logic                              r_done, r_hit;
    logic [VB-1:0]                     r_value;
    logic [VB-1:0]                     r_value_other;
    logic [1:0]                        r_status;
    logic                              r_shift_rd;

    logic             fill_we;
    logic [RB-1:0]    fill_addr;
    logic [FB-1:0]    fill_wdata, fill_rdata;
    logic             cell_we;
    logic [AB-1:0]    cell_addr;
    logic [CELLB-1:0] cell_wdata, cell_rdata;

    logic [COLUMN_BITS-1:0] rd_col;
    logic [VB-1:0]          rd_first, rd_second, rd_plane, sum_sat;
    logic [VB:0]            sum;
    logic [FB-1:0]          mid;
    logic [AB-1:0]          base;
    logic [sra_pkg::COL_PORT_BITS-1:0] col_in;
    logic                   in_range, accept, cell_hit, row_full;

    sra_ram #(.WIDTH(FB), .DEPTH(ROWS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_addr(fill_addr),
        .i_wdata(fill_wdata), .o_rdata(fill_rdata)
    );
    sra_ram #(.WIDTH(CELLB), .DEPTH(DEPTH)) u_cell (
        .i_clk(i_clk), .i_we(cell_we), .i_addr(cell_addr),
        .i_wdata(cell_wdata), .o_rdata(cell_rdata)
    );

    assign col_in   = i_column_index & sra_pkg::COL_PORT_BITS'((64'd1 << COLUMN_BITS) - 1);
    assign in_range = (i_row_index != '0) && (i_row_index <= r_row_count)
                   && (32'(i_row_index) <= 32'(ROWS))
                   && (col_in != '0) && (col_in <= r_column_count);
    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);

    assign rd_col    = cell_rdata[CELLB-1 -: COLUMN_BITS];
    assign rd_first  = cell_rdata[2*VB-1 -: VB];
    assign rd_second = cell_rdata[VB-1:0];
    assign rd_plane  = r_plane ? rd_first : rd_second;
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign base      = AB'(r_row) * AB'(ROW_CAPACITY);
    assign cell_hit  = (r_lo < r_fill) && (rd_col == r_col);
    assign row_full  = (r_fill >= FB'(ROW_CAPACITY));

    always_comb begin
        n_state    = r_state;
        fill_we    = 1'b0;
        fill_addr  = r_row;
        fill_wdata = r_fill + FB'(1);
        cell_we    = 1'b0;
        cell_addr  = base + AB'(mid);
        cell_wdata = cell_rdata;
        sum        = '0;
        sum_sat    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_range) begin
                    n_state = S_FILL;
                end
            end
            S_FILL:  n_state = S_FWAIT;
            S_FWAIT: n_state = S_PROBE;
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else begin
                    cell_addr = base + AB'(r_lo);
                    n_state   = S_CELL;
                end
            end
            S_CMP: n_state = S_PROBE;
            S_CELL: begin
                cell_addr = base + AB'(r_lo);
                if (cell_hit || r_req == sra_pkg::REQ_READ) begin
                    n_state = (r_req == sra_pkg::REQ_READ) ? S_IDLE : S_WRITE;
                end else if (row_full) begin
                    n_state = S_IDLE;
                end else if (r_k > r_lo) begin
                    cell_addr = base + AB'(r_k - FB'(1));
                    n_state   = S_SHIFT;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT: begin
                cell_addr = base + AB'(r_k);
                if (r_shift_rd) begin
                    cell_we = 1'b1;
                    if (r_k - FB'(1) > r_lo) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else begin
                    cell_addr = base + AB'(r_k - FB'(1));
                end
            end
            S_WRITE: begin
                cell_addr = base + AB'(r_lo);
                cell_we   = 1'b1;
                if (r_hit) begin
                    sum = {1'b0, r_value} + (VB+1)'(r_amount);
                end else begin
                    sum = (VB+1)'(r_amount);
                end
                sum_sat = sum[VB] ? sra_pkg::VALUE_MAX : sum[VB-1:0];
                if (r_hit) begin
                    cell_wdata = r_plane ? {r_col, sum_sat, r_value_other}
                                         : {r_col, r_value_other, sum_sat};
                end else begin
                    cell_wdata = r_plane ? {r_col, sum_sat, {VB{1'b0}}}
                                         : {r_col, {VB{1'b0}}, sum_sat};
                    fill_we = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_row_count    <= sra_pkg::ROW_BITS'(256);
            r_column_count <= '1;
            r_fill_valid   <= '0;
            r_done         <= 1'b0;
            r_shift_rd     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_IDLE && accept && !in_range)
                    || (r_state == S_CELL && (r_req == sra_pkg::REQ_READ
                        || (!cell_hit && row_full)))
                    || (r_state == S_WRITE);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sra_pkg::CFG_ROW_COUNT:
                        r_row_count <= i_cfg_data[sra_pkg::ROW_BITS-1:0];
                    sra_pkg::CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_WRITE && !r_hit) begin
                r_fill_valid[r_row] <= 1'b1;
            end
            r_shift_rd <= (r_state == S_SHIFT) ? !r_shift_rd : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req    <= i_req_type;
                r_plane  <= i_plane;
                r_row    <= RB'(i_row_index - sra_pkg::ROW_BITS'(1));
                r_col    <= COLUMN_BITS'(col_in);
                r_amount <= i_amount;
                r_hit    <= 1'b0;
                r_value  <= '0;
                r_status <= sra_pkg::ST_RANGE;
            end
            S_FILL: ;
            S_FWAIT: begin
                r_fill   <= r_fill_valid[r_row] ? fill_rdata : '0;
                r_lo     <= '0;
                r_hi     <= r_fill_valid[r_row] ? fill_rdata : '0;
                r_k      <= r_fill_valid[r_row] ? fill_rdata : '0;
                r_status <= sra_pkg::ST_OK;
            end
            S_PROBE: ;
            S_CMP: begin
                if (rd_col < r_col) begin
                    r_lo <= mid + FB'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            S_CELL: begin
                r_hit         <= cell_hit;
                r_value_other <= r_plane ? rd_second : rd_first;
                if (r_req == sra_pkg::REQ_READ) begin
                    r_value <= cell_hit ? rd_plane : '0;
                end else if (!cell_hit && row_full) begin
                    r_value  <= '0;
                    r_status <= sra_pkg::ST_FULL;
                end else begin
                    r_value <= rd_plane;
                end
            end
            S_SHIFT: begin
                if (r_shift_rd) begin
                    r_k <= r_k - FB'(1);
                end
            end
            S_WRITE: begin
                r_value <= sum_sat;
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_hit    = r_hit;
    assign o_status = r_status;
endmodule

@@ sv/sra_checker.sv @@
// Port-level checker for the sparse row accumulator store
`timescale 1ns / 1ps
module sra_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic                           o_hit,
    input logic [sra_pkg::VALUE_BITS-1:0] o_value,
    input logic [1:0]                     o_status
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == sra_pkg::ST_OK || o_status == sra_pkg::ST_RANGE
                    || o_status == sra_pkg::ST_FULL))
        else $error("bad status code");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != sra_pkg::ST_OK) |-> (o_value == '0 && !o_hit))
        else $error("error result carries data");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("item ended without result");
endmodule

bind sparse_row_accumulator_store sra_checker u_sra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_hit(o_hit), .o_value(o_value), .o_status(o_status)
);

@@ sim/tb_sparse_row_accumulator_store.sv @@
// Testbench for the sparse row accumulator store: items checked against a predictor
`timescale 1ns / 1ps
module tb_sparse_row_accumulator_store;
    localparam int NROWS      = sra_pkg::ROWS_DEF;
    localparam int CAP        = sra_pkg::ROW_CAPACITY_DEF;
    localparam int VBITS      = sra_pkg::VALUE_BITS;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [VBITS-1:0] value;
        logic             hit;
        sra_pkg::t_status status;
    } t_cell_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                i_req_type = sra_pkg::REQ_READ;
    logic                                i_plane = 1'b0;
    logic [sra_pkg::ROW_BITS-1:0]        i_row_index = '0;
    logic [sra_pkg::COL_PORT_BITS-1:0]   i_column_index = '0;
    logic [sra_pkg::AMOUNT_BITS-1:0]     i_amount = '0;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_index = sra_pkg::CFG_ROW_COUNT;
    logic [sra_pkg::CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    logic                                o_done;
    logic [VBITS-1:0]                    o_value;
    logic                                o_hit;
    logic [1:0]                          o_status;

    logic [15:0]       model_col   [NROWS][CAP];
    logic [VBITS-1:0]  model_first [NROWS][CAP];
    logic [VBITS-1:0]  model_second[NROWS][CAP];
    int unsigned       model_fill  [NROWS];
    logic [8:0]        model_rows;
    logic [15:0]       model_cols;

    t_cell_result pending_results[$];
    int unsigned  idle_pct = 0;
    int unsigned  mismatches = 0;
    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    sparse_row_accumulator_store uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_plane(i_plane), .i_row_index(i_row_index),
        .i_column_index(i_column_index), .i_amount(i_amount),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_value(o_value), .o_hit(o_hit), .o_status(o_status)
    );

    task automatic predict_cell(input logic req, input logic pl, input logic [8:0] row,
                                input logic [15:0] col, input logic [31:0] amt,
                                output t_cell_result res);
        int unsigned r, fill, lo, hi, mid, k;
        logic found;
        logic [VBITS:0] sum;
        logic [VBITS-1:0] cur;
        res = '{value: '0, hit: 1'b0, status: sra_pkg::ST_OK};
        if (row == 0 || row > model_rows || row > NROWS || col == 0 || col > model_cols) begin
            res.status = sra_pkg::ST_RANGE;
            return;
        end
        r = row - 1;
        fill = model_fill[r];
        lo = 0;
        hi = fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_col[r][mid] < col) lo = mid + 1;
            else hi = mid;
        end
        found = (lo < fill) && (model_col[r][lo] == col);
        if (req == sra_pkg::REQ_READ) begin
            if (found) begin
                res.value = pl ? model_first[r][lo] : model_second[r][lo];
                res.hit = 1'b1;
            end
            return;
        end
        if (!found) begin
            if (fill >= CAP) begin
                res.status = sra_pkg::ST_FULL;
                return;
            end
            for (k = fill; k > lo; k--) begin
                model_col[r][k]    = model_col[r][k-1];
                model_first[r][k]  = model_first[r][k-1];
                model_second[r][k] = model_second[r][k-1];
            end
            model_col[r][lo]    = col;
            model_first[r][lo]  = '0;
            model_second[r][lo] = '0;
            model_fill[r] = fill + 1;
        end
        cur = pl ? model_first[r][lo] : model_second[r][lo];
        sum = {1'b0, cur} + (VBITS+1)'(amt);
        if (sum > {1'b0, sra_pkg::VALUE_MAX}) sum = {1'b0, sra_pkg::VALUE_MAX};
        if (pl) model_first[r][lo] = sum[VBITS-1:0];
        else model_second[r][lo] = sum[VBITS-1:0];
        res.value = sum[VBITS-1:0];
        res.hit = found;
    endtask

    task automatic send_item(input logic req, input logic pl, input logic [8:0] row,
                             input logic [15:0] col, input logic [31:0] amt);
        logic b;
        t_cell_result res;
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req_type <= req;
        i_plane <= pl;
        i_row_index <= row;
        i_column_index <= col;
        i_amount <= amt;
        b = busy;
        @(posedge i_clk);
        while (b) begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
        end
        predict_cell(req, pl, row, col, amt, res);
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sra_pkg::CFG_ROW_COUNT) model_rows = data[8:0];
        else model_cols = data;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%h hit=%b status=%0d",
                             o_value, o_hit, o_status);
            end else begin
                t_cell_result exp_res;
                exp_res = pending_results.pop_front();
                if (o_value !== exp_res.value || o_hit !== exp_res.hit ||
                    o_status !== exp_res.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%h hit=%b status=%0d, %s",
                                 exp_res.value, exp_res.hit, exp_res.status,
                                 $sformatf("got value=%h hit=%b status=%0d",
                                           o_value, o_hit, o_status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WDOG_LIMIT);
        $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic test_directed();
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd1, 16'd1, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd1, 16'd1, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd1, 16'd1, 32'hFFFF_FFFF);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd1, 16'd1, 32'hFFFF_FFFF);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd1, 16'd1, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd256, 16'd65535, 32'd5);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd256, 16'd65535, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd0, 16'd5, 32'd7);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd1, 16'd0, 32'd7);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd257, 16'd1, 32'd0);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd511, 16'd65535, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd1, 16'd100, 32'd11);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd1, 16'd50, 32'd22);
        send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd1, 16'd75, 32'd33);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd1, 16'd100, 32'd0);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd1, 16'd50, 32'd0);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd1, 16'd60, 32'd0);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'hFE01);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'd1);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd1, 16'd1, 32'd1);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd1, 16'd2, 32'd0);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd2, 16'd1, 32'd0);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd1, 16'd1, 32'd1);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'd256);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'hFFFF);
    endtask

    task automatic test_row_full();
        logic [15:0] c;
        for (int i = 0; i < CAP; i++) begin
            c = 16'(($urandom_range(0, 999) * 64) + i + 1);
            send_item(sra_pkg::REQ_INCREMENT, 1'($urandom_range(0, 1)), 9'd2, c, $urandom);
        end
        send_item(sra_pkg::REQ_INCREMENT, 1'b1, 9'd2, 16'd65535, 32'd9);
        send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd2, 16'd1, 32'd9);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd2, c, 32'd0);
        send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd2, c, 32'd1);
    endtask

    task automatic test_large_sums();
        for (int i = 0; i < 20; i++)
            send_item(sra_pkg::REQ_INCREMENT, 1'b0, 9'd3, 16'd300, 32'hFFFF_FFFF);
        send_item(sra_pkg::REQ_READ, 1'b0, 9'd3, 16'd300, 32'd0);
        send_item(sra_pkg::REQ_READ, 1'b1, 9'd3, 16'd300, 32'd0);
    endtask

    task automatic test_random(input int unsigned pct, input int unsigned count);
        logic [8:0] row;
        logic [15:0] col;
        logic [31:0] amt;
        idle_pct = pct;
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                row = 9'($urandom);
                col = 16'($urandom);
            end else begin
                case ($urandom_range(0, 5))
                    0: row = 9'd256;
                    1: row = 9'($urandom_range(1, 2));
                    default: row = 9'($urandom_range(4, 9));
                endcase
                if ($urandom_range(0, 3) == 0) col = 16'($urandom_range(1, 65535));
                else col = 16'($urandom_range(1, 48)) * 16'd997;
            end
            amt = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 5000));
            send_item($urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)), row, col, amt);
        end
    endtask

    initial begin
        for (int r = 0; r < NROWS; r++) model_fill[r] = 0;
        model_rows = 9'd256;
        model_cols = 16'd65535;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_row_full();
        test_random(0, 85);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'd8);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'd20000);
        test_random(54, 85);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'd300);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'hFFFF);
        test_random(0, 85);
        write_reg(sra_pkg::CFG_ROW_COUNT, 16'd256);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'd30000);
        test_random(27, 85);
        write_reg(sra_pkg::CFG_COLUMN_COUNT, 16'hFFFF);
        idle_pct = 0;
        test_large_sums();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge i_clk);
        mismatches += pending_results.size();
        $display("sent %0d items, checked %0d results, %0d mismatches", items_sent,
                 results_seen, mismatches);
        $display("covered range errors, row full, inserts, large sums and register settings");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
